@@ rtl/tpaf_pkg.sv @@
// Shared constants, types and tables of the three-point arc fit pipeline.
`timescale 1ns / 1ps
`default_nettype none
package tpaf_pkg;

  // Field and datapath widths
  localparam int COORD_W      = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int DIFF_W       = 33;
  localparam int NUM_W        = 100;
  localparam int DEN_W        = 66;
  localparam int QUO_W        = 34;
  localparam int DIV_STAGES   = QUO_W + 1;
  localparam int VEC_W        = 36;
  localparam int NORM_W       = 41;
  localparam int CW_W         = 45;
  localparam int CZ_W         = 33;
  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = 32;
  localparam int SQRT_LAT     = SQRT_STEPS + 1;

  // Turning direction codes
  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_CCW  = 2'd1,
    TURN_CW   = 2'd2
  } turn_t;

  // Per-item side information leaving the front end
  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [DIFF_W-1:0]  bx;
    logic signed [DIFF_W-1:0]  by;
    logic                      cneg;
    logic                      coll;
    logic                      negx;
    logic                      negy;
  } front_side_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tpaf_if.sv @@
// Handshake interfaces for the arc point words and the circle result words.
`timescale 1ns / 1ps
`default_nettype none
interface tpaf_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        start_x;
  logic signed [31:0]        start_y;
  logic signed [31:0]        mid_x;
  logic signed [31:0]        mid_y;
  logic signed [31:0]        end_x;
  logic signed [31:0]        end_y;

  modport source (output valid, start_x, start_y, mid_x, mid_y, end_x, end_y,
                  input ready);
  modport sink   (input valid, start_x, start_y, mid_x, mid_y, end_x, end_y,
                  output ready);
endinterface

interface tpaf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [31:0]                centre_x;
  logic signed [31:0]                centre_y;
  logic [31:0]                       radius;
  logic [tpaf_pkg::ANGLE_BITS-1:0]   from_angle;
  logic [tpaf_pkg::ANGLE_BITS-1:0]   to_angle;
  logic [1:0]                        turn_direction;
  logic                              collinear_error;
  logic                              saturated;

  modport source (output valid, centre_x, centre_y, radius, from_angle, to_angle,
                  turn_direction, collinear_error, saturated, input ready);
  modport sink   (input valid, centre_x, centre_y, radius, from_angle, to_angle,
                  turn_direction, collinear_error, saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/tpaf_front.sv @@
// Front end: relative vectors, cross product, squared lengths and the centre numerators.
`timescale 1ns / 1ps
`default_nettype none
module tpaf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [31:0]                  start_x,
  input  logic signed [31:0]                  start_y,
  input  logic signed [31:0]                  mid_x,
  input  logic signed [31:0]                  mid_y,
  input  logic signed [31:0]                  end_x,
  input  logic signed [31:0]                  end_y,
  output logic                                out_vld,
  output logic [tpaf_pkg::NUM_W-1:0]          numx,
  output logic [tpaf_pkg::NUM_W-1:0]          numy,
  output logic [tpaf_pkg::DEN_W-1:0]          den,
  output tpaf_pkg::front_side_t               side
);

  logic [8:1]                               vld_r;
  tpaf_pkg::front_side_t                    side_r [1:8];
  tpaf_pkg::front_side_t                    side7_nxt;
  logic signed [tpaf_pkg::DIFF_W-1:0]       ax_r [1:3];
  logic signed [tpaf_pkg::DIFF_W-1:0]       ay_r [1:3];
  logic signed [65:0]                       axby_r, aybx_r;
  logic signed [65:0]                       sq_ax, sq_ay, sq_bx, sq_by;
  logic [63:0]                              ax2_r, ay2_r, bx2_r, by2_r;
  logic signed [65:0]                       c3_r, c4_r, c5_r, c6_r;
  logic signed [65:0]                       c_neg;
  logic [64:0]                              sa_r, sb_r;
  logic signed [66:0]                       by_sal_r, ay_sbl_r, ax_sbl_r, bx_sal_r;
  logic signed [65:0]                       by_sah_r, ay_sbh_r, ax_sbh_r, bx_sah_r;
  logic signed [99:0]                       by_sa_r, ay_sb_r, ax_sb_r, bx_sa_r;
  logic signed [99:0]                       nx_r, ny_r, nx_neg, ny_neg;
  logic [98:0]                              nxm_r, nym_r;
  logic [64:0]                              cm_r;
  logic [tpaf_pkg::NUM_W-1:0]               numx_r, numy_r;
  logic [tpaf_pkg::DEN_W-1:0]               den_r;

  // Valid bits travel stage by stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:1], in_vld};
    end
  end

  // Squares are non-negative and fit in 64 bits.
  always_comb begin
    sq_ax = 66'(ax_r[1]) * 66'(ax_r[1]);
    sq_ay = 66'(ay_r[1]) * 66'(ay_r[1]);
    sq_bx = 66'(side_r[1].bx) * 66'(side_r[1].bx);
    sq_by = 66'(side_r[1].by) * 66'(side_r[1].by);
  end

  // Magnitudes and signs for the divider.
  always_comb begin
    nx_neg         = -nx_r;
    ny_neg         = -ny_r;
    c_neg          = -c6_r;
    side7_nxt      = side_r[6];
    side7_nxt.cneg = c6_r[65];
    side7_nxt.coll = (c6_r == '0);
    side7_nxt.negx = nx_r[99] ^ c6_r[65];
    side7_nxt.negy = ny_r[99] ^ c6_r[65];
  end

  // Datapath stages one to eight
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: vectors relative to the start point
      ax_r[1]        <= 33'(mid_x) - 33'(start_x);
      ay_r[1]        <= 33'(mid_y) - 33'(start_y);
      side_r[1].x0   <= start_x;
      side_r[1].y0   <= start_y;
      side_r[1].bx   <= 33'(end_x) - 33'(start_x);
      side_r[1].by   <= 33'(end_y) - 33'(start_y);
      side_r[1].cneg <= 1'b0;
      side_r[1].coll <= 1'b0;
      side_r[1].negx <= 1'b0;
      side_r[1].negy <= 1'b0;
      for (int k = 2; k <= 3; k++) begin
        ax_r[k] <= ax_r[k-1];
        ay_r[k] <= ay_r[k-1];
      end
      for (int k = 2; k <= 8; k++) begin
        if (k != 7) begin
          side_r[k] <= side_r[k-1];
        end
      end
      side_r[7] <= side7_nxt;

      // Stage 2: cross terms and squares
      axby_r <= 66'(ax_r[1]) * 66'(side_r[1].by);
      aybx_r <= 66'(ay_r[1]) * 66'(side_r[1].bx);
      ax2_r  <= sq_ax[63:0];
      ay2_r  <= sq_ay[63:0];
      bx2_r  <= sq_bx[63:0];
      by2_r  <= sq_by[63:0];

      // Stage 3: cross product and squared lengths
      c3_r <= axby_r - aybx_r;
      sa_r <= 65'(ax2_r) + 65'(ay2_r);
      sb_r <= 65'(bx2_r) + 65'(by2_r);

      // Stage 4: partial products of the numerators, long operand split in two
      by_sal_r <= 67'(side_r[3].by) * 67'($signed({1'b0, sa_r[32:0]}));
      by_sah_r <= 66'(side_r[3].by) * 66'($signed({1'b0, sa_r[64:33]}));
      ay_sbl_r <= 67'(ay_r[3]) * 67'($signed({1'b0, sb_r[32:0]}));
      ay_sbh_r <= 66'(ay_r[3]) * 66'($signed({1'b0, sb_r[64:33]}));
      ax_sbl_r <= 67'(ax_r[3]) * 67'($signed({1'b0, sb_r[32:0]}));
      ax_sbh_r <= 66'(ax_r[3]) * 66'($signed({1'b0, sb_r[64:33]}));
      bx_sal_r <= 67'(side_r[3].bx) * 67'($signed({1'b0, sa_r[32:0]}));
      bx_sah_r <= 66'(side_r[3].bx) * 66'($signed({1'b0, sa_r[64:33]}));
      c4_r     <= c3_r;

      // Stage 5: recombine the partial products
      by_sa_r <= (100'(by_sah_r) <<< 33) + 100'(by_sal_r);
      ay_sb_r <= (100'(ay_sbh_r) <<< 33) + 100'(ay_sbl_r);
      ax_sb_r <= (100'(ax_sbh_r) <<< 33) + 100'(ax_sbl_r);
      bx_sa_r <= (100'(bx_sah_r) <<< 33) + 100'(bx_sal_r);
      c5_r    <= c4_r;

      // Stage 6: centre numerators
      nx_r <= by_sa_r - ay_sb_r;
      ny_r <= ax_sb_r - bx_sa_r;
      c6_r <= c5_r;

      // Stage 7: magnitudes
      nxm_r <= nx_r[99] ? nx_neg[98:0] : nx_r[98:0];
      nym_r <= ny_r[99] ? ny_neg[98:0] : ny_r[98:0];
      cm_r  <= c6_r[65] ? c_neg[64:0] : c6_r[64:0];

      // Stage 8: add half the divisor so that the floor division rounds
      numx_r <= 100'(nxm_r) + 100'(cm_r);
      numy_r <= 100'(nym_r) + 100'(cm_r);
      den_r  <= {cm_r, 1'b0};
    end
  end

  assign out_vld = vld_r[8];
  assign numx    = numx_r;
  assign numy    = numy_r;
  assign den     = den_r;
  assign side    = side_r[8];

endmodule
`default_nettype wire

@@ rtl/tpaf_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module tpaf_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [tpaf_pkg::NUM_W-1:0]     num,
  input  logic [tpaf_pkg::DEN_W-1:0]     den,
  output logic                           out_vld,
  output logic [tpaf_pkg::QUO_W-1:0]     quo,
  output logic                           ovf
);

  localparam int QW = tpaf_pkg::QUO_W;

  logic [QW:0]                      vld_r;
  logic [tpaf_pkg::NUM_W-1:0]       rem_r [0:QW];
  logic [tpaf_pkg::DEN_W-1:0]       den_r [0:QW];
  logic [QW-1:0]                    quo_r [0:QW];
  logic [QW:0]                      ovf_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_vld};
    end
  end

  // Entry stage: a quotient of 2^QW or more is flagged as overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= (num >= {den, QW'(0)});
    end
  end

  // One compare and subtract per stage, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [tpaf_pkg::NUM_W-1:0] dsh;
    logic                       take;

    always_comb begin
      dsh  = tpaf_pkg::NUM_W'(den_r[k-1]) << (QW - k);
      take = (rem_r[k-1] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? (rem_r[k-1] - dsh) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= quo_r[k-1] | (take ? (QW'(1) << (QW - k)) : QW'(0));
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign quo     = quo_r[QW];
  assign ovf     = ovf_r[QW];

endmodule
`default_nettype wire

@@ rtl/tpaf_sqrt.sv @@
// Pipelined integer square root of a 64-bit value, rounded to nearest.
`timescale 1ns / 1ps
`default_nettype none
module tpaf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] radicand,
  output logic        out_vld,
  output logic [31:0] root
);

  localparam int NS = tpaf_pkg::SQRT_STEPS;

  logic [NS:0]  vld_r;
  logic [63:0]  rem_r [0:NS-1];
  logic [63:0]  res_r [0:NS-1];
  logic [32:0]  rnd;
  logic [31:0]  root_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-1:0], in_vld};
    end
  end

  // One result bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [63:0] rin, sin, bitv, trial;

    if (k == 0) begin : g_first
      assign rin = radicand;
      assign sin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign sin = res_r[k-1];
    end

    always_comb begin
      bitv  = 64'd1 << (62 - 2 * k);
      trial = sin + bitv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem_r[k] <= rin - trial;
          res_r[k] <= (sin >> 1) + bitv;
        end else begin
          rem_r[k] <= rin;
          res_r[k] <= sin >> 1;
        end
      end
    end
  end

  // Round up when the remainder exceeds the root.
  always_comb begin
    rnd = 33'(res_r[NS-1][31:0]) + ((rem_r[NS-1] > res_r[NS-1]) ? 33'd1 : 33'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= rnd[31:0];
    end
  end

  assign out_vld = vld_r[NS];
  assign root    = root_r;

endmodule
`default_nettype wire

@@ rtl/tpaf_cordic.sv @@
// Pipelined vectoring CORDIC giving the binary angle of a vector.
`timescale 1ns / 1ps
`default_nettype none
module tpaf_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [tpaf_pkg::VEC_W-1:0]    vx,
  input  logic signed [tpaf_pkg::VEC_W-1:0]    vy,
  output logic                                 out_vld,
  output logic [tpaf_pkg::ANGLE_BITS-1:0]      angle
);

  localparam int NS = tpaf_pkg::CORDIC_STEPS;
  localparam int CW = tpaf_pkg::CW_W;
  localparam int CZ = tpaf_pkg::CZ_W;
  localparam int NW = tpaf_pkg::NORM_W;
  localparam int AB = tpaf_pkg::ANGLE_BITS;

  typedef struct packed {
    logic swp;
    logic xneg;
    logic yneg;
    logic zero;
  } fold_t;

  // Valid: fold, two normalise stages, the steps, then three finishing stages
  logic [NS+5:0]          vld_r;
  logic [NW-1:0]          ux_r, uy_r, n1x_r, n1y_r;
  logic [NW-1:0]          ux_m, uy_m, ax_abs, ay_abs, n1x, n1y, n2x, n2y;
  fold_t                  f0_r, f1_r, fe1_r, fe2_r;
  fold_t                  fl_r [0:NS];
  logic signed [CW-1:0]   x_r [0:NS];
  logic signed [CW-1:0]   y_r [0:NS];
  logic signed [CZ-1:0]   z_r [0:NS];
  logic [29:0]            zc;
  logic [31:0]            a1_r, a2_r, a2s, ang_sum;
  logic signed [tpaf_pkg::VEC_W-1:0] vx_neg, vy_neg;
  logic [AB-1:0]          angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS+4:0], in_vld};
    end
  end

  // Fold into the first octant.
  always_comb begin
    vx_neg = -vx;
    vy_neg = -vy;
    ax_abs = NW'(vx[tpaf_pkg::VEC_W-1] ? $unsigned(vx_neg) : $unsigned(vx));
    ay_abs = NW'(vy[tpaf_pkg::VEC_W-1] ? $unsigned(vy_neg) : $unsigned(vy));
    if (ay_abs > ax_abs) begin
      ux_m = ay_abs;
      uy_m = ax_abs;
    end else begin
      ux_m = ax_abs;
      uy_m = ay_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r    <= ux_m;
      uy_r    <= uy_m;
      f0_r    <= '{swp: (ay_abs > ax_abs), xneg: vx[tpaf_pkg::VEC_W-1],
                   yneg: vy[tpaf_pkg::VEC_W-1], zero: (ux_m == '0)};
    end
  end

  // Normalise the larger component into [2^40, 2^41) over two stages.
  always_comb begin
    n1x = ux_r;
    n1y = uy_r;
    if ((n1x >> (NW - 32)) == '0) begin n1x = n1x << 32; n1y = n1y << 32; end
    if ((n1x >> (NW - 16)) == '0) begin n1x = n1x << 16; n1y = n1y << 16; end
    if ((n1x >> (NW - 8)) == '0)  begin n1x = n1x << 8;  n1y = n1y << 8;  end
    n2x = n1x_r;
    n2y = n1y_r;
    if ((n2x >> (NW - 4)) == '0)  begin n2x = n2x << 4;  n2y = n2y << 4;  end
    if ((n2x >> (NW - 2)) == '0)  begin n2x = n2x << 2;  n2y = n2y << 2;  end
    if ((n2x >> (NW - 1)) == '0)  begin n2x = n2x << 1;  n2y = n2y << 1;  end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1x_r  <= n1x;
      n1y_r  <= n1y;
      f1_r   <= f0_r;
      x_r[0] <= $signed(CW'(n2x));
      y_r[0] <= $signed(CW'(n2y));
      z_r[0] <= '0;
      fl_r[0] <= f1_r;
    end
  end

  // Vectoring steps with floor shifts
  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    logic signed [CZ-1:0] at;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      at = $signed({1'b0, tpaf_pkg::atan_turn(5'(i))});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[i+1] <= fl_r[i];
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end
      end
    end
  end

  // Clamp to one octant, unfold, and round to the output width.
  always_comb begin
    if (z_r[NS][CZ-1]) begin
      zc = '0;
    end else if (z_r[NS] > $signed(CZ'(1 << 29))) begin
      zc = 30'(1 << 29);
    end else begin
      zc = z_r[NS][29:0];
    end
    a2s     = fe2_r.yneg ? (32'd0 - a2_r) : a2_r;
    ang_sum = a2s + 32'(1 << (31 - AB));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fe1_r   <= fl_r[NS];
      a1_r    <= fl_r[NS].swp ? (32'(1 << 30) - 32'(zc)) : 32'(zc);
      fe2_r   <= fe1_r;
      a2_r    <= fe1_r.xneg ? (32'h8000_0000 - a1_r) : a1_r;
      angle_r <= fe2_r.zero ? '0 : ang_sum[31 -: AB];
    end
  end

  assign out_vld = vld_r[NS+5];
  assign angle   = angle_r;

endmodule
`default_nettype wire

@@ rtl/three_point_arc_fit_core.sv @@
// Top level of the circle fit through three arc points.
// Throughput: one word per cycle; the 35-stage dividers, the 33-stage square
// root and the 34-stage CORDIC units are fully pipelined and set the latency.
// A stall on the result side freezes the whole pipeline without loss.
// Reset (synchronous, active low) clears every valid bit; no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module three_point_arc_fit_core (
  input  logic             clk,
  input  logic             rst_n,
  tpaf_in_if.sink          in_ch,
  tpaf_out_if.source       out_ch
);

  localparam int DS = tpaf_pkg::DIV_STAGES;
  localparam int SL = tpaf_pkg::SQRT_LAT;
  localparam int AB = tpaf_pkg::ANGLE_BITS;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               sat;
    logic               rsat;
    logic               coll;
    logic               cneg;
  } out_side_t;

  logic                                en;
  logic                                f_vld, dvx_vld, dvy_vld, sq_vld, cs_vld, ce_vld;
  logic [tpaf_pkg::NUM_W-1:0]          numx, numy;
  logic [tpaf_pkg::DEN_W-1:0]          den;
  tpaf_pkg::front_side_t               f_side;
  tpaf_pkg::front_side_t               side_d_r [0:DS-1];
  logic [tpaf_pkg::QUO_W-1:0]          quox, quoy, qmx, qmy;
  logic                                ovfx, ovfy, clx, cly;
  logic                                p1_vld_r, p2_vld_r, p3_vld_r;
  logic signed [34:0]                  qx_r, qy_r;
  tpaf_pkg::front_side_t               p1_side_r;
  logic                                p1_sat_r, p2_sat_r;
  logic signed [35:0]                  cxs_r, cys_r;
  logic [66:0]                         qsx_r, qsy_r;
  logic signed [69:0]                  qsx_f, qsy_f;
  logic signed [tpaf_pkg::VEC_W-1:0]   vsx_r, vsy_r, vex_r, vey_r;
  logic                                p2_coll_r, p2_cneg_r;
  logic [67:0]                         r2;
  logic                                ovx, ovy;
  out_side_t                           p3_side_r;
  logic [63:0]                         rad_in_r;
  out_side_t                           side2_r [0:SL-1];
  logic [31:0]                         root;
  logic [AB-1:0]                       sang, eang;
  logic                                out_vld_r;
  logic signed [31:0]                  ocx_r, ocy_r;
  logic [31:0]                         orad_r;
  logic [AB-1:0]                       osang_r, oeang_r;
  logic [1:0]                          odir_r;
  logic                                ocoll_r, osat_r;
  out_side_t                           fin;

  // The whole pipeline advances unless a finished word is held.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  tpaf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .start_x (in_ch.start_x),
    .start_y (in_ch.start_y),
    .mid_x   (in_ch.mid_x),
    .mid_y   (in_ch.mid_y),
    .end_x   (in_ch.end_x),
    .end_y   (in_ch.end_y),
    .out_vld (f_vld),
    .numx    (numx),
    .numy    (numy),
    .den     (den),
    .side    (f_side)
  );

  tpaf_divider u_div_x (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (f_vld),
    .num (numx), .den (den), .out_vld (dvx_vld), .quo (quox), .ovf (ovfx)
  );

  tpaf_divider u_div_y (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (f_vld),
    .num (numy), .den (den), .out_vld (dvy_vld), .quo (quoy), .ovf (ovfy)
  );

  // Side information delayed alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= f_side;
      for (int k = 1; k < DS; k++) begin
        side_d_r[k] <= side_d_r[k-1];
      end
    end
  end

  // Clamp the quotient magnitudes to 2^33.
  always_comb begin
    clx = ovfx || (quox > tpaf_pkg::QUO_W'(64'd1 << 33));
    cly = ovfy || (quoy > tpaf_pkg::QUO_W'(64'd1 << 33));
    qmx = clx ? tpaf_pkg::QUO_W'(64'd1 << 33) : quox;
    qmy = cly ? tpaf_pkg::QUO_W'(64'd1 << 33) : quoy;
    qsx_f = 70'(qx_r) * 70'(qx_r);
    qsy_f = 70'(qy_r) * 70'(qy_r);
    r2  = 68'(qsx_r) + 68'(qsy_r);
    ovx = !((&cxs_r[35:31]) || !(|cxs_r[35:31]));
    ovy = !((&cys_r[35:31]) || !(|cys_r[35:31]));
  end

  // Post-divide stages: signed offsets, centre sums and squares, saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= dvx_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage P1
      qx_r      <= side_d_r[DS-1].negx ? -$signed(35'(qmx)) : $signed(35'(qmx));
      qy_r      <= side_d_r[DS-1].negy ? -$signed(35'(qmy)) : $signed(35'(qmy));
      p1_side_r <= side_d_r[DS-1];
      p1_sat_r  <= clx || cly;
      // Stage P2
      cxs_r     <= 36'(p1_side_r.x0) + 36'(qx_r);
      cys_r     <= 36'(p1_side_r.y0) + 36'(qy_r);
      qsx_r     <= qsx_f[66:0];
      qsy_r     <= qsy_f[66:0];
      vsx_r     <= -(36'(qx_r));
      vsy_r     <= -(36'(qy_r));
      vex_r     <= 36'(p1_side_r.bx) - 36'(qx_r);
      vey_r     <= 36'(p1_side_r.by) - 36'(qy_r);
      p2_sat_r  <= p1_sat_r;
      p2_coll_r <= p1_side_r.coll;
      p2_cneg_r <= p1_side_r.cneg;
      // Stage P3
      p3_side_r.cx   <= ovx ? (cxs_r[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : cxs_r[31:0];
      p3_side_r.cy   <= ovy ? (cys_r[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : cys_r[31:0];
      p3_side_r.sat  <= p2_sat_r || ovx || ovy;
      p3_side_r.rsat <= (r2 > 68'h0_FFFF_FFFF_0000_0000);
      p3_side_r.coll <= p2_coll_r;
      p3_side_r.cneg <= p2_cneg_r;
      rad_in_r       <= r2[63:0];
    end
  end

  tpaf_sqrt u_sqrt (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (p3_vld_r),
    .radicand (rad_in_r), .out_vld (sq_vld), .root (root)
  );

  tpaf_cordic u_ang_start (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (p2_vld_r),
    .vx (vsx_r), .vy (vsy_r), .out_vld (cs_vld), .angle (sang)
  );

  tpaf_cordic u_ang_end (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (p2_vld_r),
    .vx (vex_r), .vy (vey_r), .out_vld (ce_vld), .angle (eang)
  );

  // Side information delayed alongside the square root
  always_ff @(posedge clk) begin
    if (en) begin
      side2_r[0] <= p3_side_r;
      for (int k = 1; k < SL; k++) begin
        side2_r[k] <= side2_r[k-1];
      end
    end
  end

  assign fin = side2_r[SL-1];

  // Output register: collinear points give a zero word with the error flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin.coll) begin
        ocx_r   <= '0;
        ocy_r   <= '0;
        orad_r  <= '0;
        osang_r <= '0;
        oeang_r <= '0;
        odir_r  <= tpaf_pkg::TURN_NONE;
        ocoll_r <= 1'b1;
        osat_r  <= 1'b0;
      end else begin
        ocx_r   <= fin.cx;
        ocy_r   <= fin.cy;
        orad_r  <= fin.rsat ? 32'hFFFF_FFFF : root;
        osang_r <= sang;
        oeang_r <= eang;
        odir_r  <= fin.cneg ? tpaf_pkg::TURN_CW : tpaf_pkg::TURN_CCW;
        ocoll_r <= 1'b0;
        osat_r  <= fin.sat || fin.rsat;
      end
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.centre_x        = ocx_r;
  assign out_ch.centre_y        = ocy_r;
  assign out_ch.radius          = orad_r;
  assign out_ch.from_angle      = osang_r;
  assign out_ch.to_angle        = oeang_r;
  assign out_ch.turn_direction  = odir_r;
  assign out_ch.collinear_error = ocoll_r;
  assign out_ch.saturated       = osat_r;

  // The parallel units must stay in step with one another.
  a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dvx_vld == dvy_vld) && (sq_vld == cs_vld) && (cs_vld == ce_vld))
    else $error("arc fit units out of step");

  // A finished word from the root unit lands in the output register.
  a_result_captured: assert property (@(posedge clk) disable iff (!rst_n)
    en && sq_vld |=> out_vld_r)
    else $error("result word lost at output register");

  // A collinear result carries no geometry.
  a_collinear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ocoll_r |-> (orad_r == '0) && (odir_r == tpaf_pkg::TURN_NONE) && !osat_r)
    else $error("collinear result not cleared");

  // With the output register empty the input is never blocked.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire
